// ===== src/coim_pkg.sv =====
// Shared types and codes for the client to order id map.
package coim_pkg;

  localparam int ID_W    = 63;
  localparam int ENTRY_W = 2 * ID_W;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CLOSE  = 2'd1;
  localparam logic [1:0] ACT_LOOKUP = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_DUPLICATE = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [1:0]      action;
    logic [ID_W-1:0] client_id;
    logic [ID_W-1:0] order_id;
  } req_t;

  typedef struct packed {
    logic [ID_W-1:0] found_order;
    logic [1:0]      status;
    logic            from_history;
  } rsp_t;

endpackage

// ===== src/client_order_id_map_top.sv =====
// Top level of the client to order id map: tables, sequencer, output register.
//
//  channel  | valid     | stall     | payload            | dir
//  request  | req_valid | req_stall | req_data (req_t)   | in
//  response | rsp_valid | rsp_stall | rsp_data (rsp_t)   | out
//
// A request is taken in idle; an add, close or lookup scans the open table up to a hit or
// its last entry, and another action code goes straight to the result. A lookup that misses
// there, or a close that hits with a non-empty history, then scans up to history count
// entries of the history. The result then loads the output register, and only after that
// is the next request taken: one request at a time, set by the single key comparator and
// the one read port of each table.
// Reset clears the open valid bits and the history head and count at once.
// A new request is taken while an earlier response waits in the output register;
// a finished result waits in the sequencer while that register is full and stalled.
module client_order_id_map_top #(
  parameter int OPEN_DEPTH    = 64,
  parameter int HISTORY_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  coim_pkg::req_t req_data,
  output logic           rsp_valid,
  input  logic           rsp_stall,
  output coim_pkg::rsp_t rsp_data
);
  import coim_pkg::*;

  localparam int OAW = $clog2(OPEN_DEPTH);
  localparam int HAW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  logic               busy, res_valid, res_take;
  rsp_t               res;
  logic               o_we, h_we;
  logic [OAW-1:0]     o_waddr, o_raddr;
  logic [HAW-1:0]     h_waddr, h_raddr;
  logic [ENTRY_W-1:0] o_wdata, o_rdata, h_wdata, h_rdata;

  assign req_stall = busy;
  assign res_take  = res_valid && (!rsp_valid || !rsp_stall);

  coim_ctrl #(
    .OPEN_DEPTH    (OPEN_DEPTH),
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .OAW           (OAW),
    .HAW           (HAW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req_data),
    .busy      (busy),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res),
    .o_we      (o_we),
    .o_waddr   (o_waddr),
    .o_wdata   (o_wdata),
    .o_raddr   (o_raddr),
    .o_rdata   (o_rdata),
    .h_we      (h_we),
    .h_waddr   (h_waddr),
    .h_wdata   (h_wdata),
    .h_raddr   (h_raddr),
    .h_rdata   (h_rdata)
  );

  coim_store #(
    .DEPTH (OPEN_DEPTH),
    .AW    (OAW),
    .DW    (ENTRY_W)
  ) u_open (
    .clk   (clk),
    .we    (o_we),
    .waddr (o_waddr),
    .wdata (o_wdata),
    .raddr (o_raddr),
    .rdata (o_rdata)
  );

  coim_store #(
    .DEPTH (HISTORY_DEPTH),
    .AW    (HAW),
    .DW    (ENTRY_W)
  ) u_hist (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp_data <= res;
    end
  end

endmodule

// ===== src/coim_store.sv =====
// Key and order store: one write port, one registered read port.
module coim_store #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 126
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/coim_ctrl.sv =====
// Sequencer: scans both tables with one key comparator and updates them.
module coim_ctrl #(
  parameter int OPEN_DEPTH    = 64,
  parameter int HISTORY_DEPTH = 16,
  parameter int OAW           = 6,
  parameter int HAW           = 4
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  input  coim_pkg::req_t                    req,
  output logic                              busy,
  output logic                              res_valid,
  input  logic                              res_take,
  output coim_pkg::rsp_t                    res,
  output logic                              o_we,
  output logic [OAW-1:0]                    o_waddr,
  output logic [coim_pkg::ENTRY_W-1:0]      o_wdata,
  output logic [OAW-1:0]                    o_raddr,
  input  logic [coim_pkg::ENTRY_W-1:0]      o_rdata,
  output logic                              h_we,
  output logic [HAW-1:0]                    h_waddr,
  output logic [coim_pkg::ENTRY_W-1:0]      h_wdata,
  output logic [HAW-1:0]                    h_raddr,
  input  logic [coim_pkg::ENTRY_W-1:0]      h_rdata
);
  import coim_pkg::*;

  localparam int CW = $clog2(HISTORY_DEPTH + 1);
  localparam logic [OAW-1:0] O_LAST = OAW'(OPEN_DEPTH - 1);
  localparam logic [HAW-1:0] H_LAST = HAW'(HISTORY_DEPTH - 1);
  localparam logic [CW-1:0]  H_FULL = CW'(HISTORY_DEPTH);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_OSCAN = 2'd1;
  localparam logic [1:0] S_HSCAN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]            state;
  logic [1:0]            act;
  logic [ID_W-1:0]       key;
  logic [ID_W-1:0]       ord;
  logic [OPEN_DEPTH-1:0] open_valid;
  logic [OAW-1:0]        oidx;
  logic [OAW-1:0]        ochk_idx;
  logic                  ochk;
  logic                  free_fnd;
  logic [OAW-1:0]        free_idx;
  logic [ID_W-1:0]       hit_order;
  logic [HAW-1:0]        hist_head;
  logic [CW-1:0]         hist_count;
  logic [HAW-1:0]        hslot;
  logic [CW-1:0]         hn;
  logic                  hchk;
  logic                  hchk_last;

  logic [ID_W-1:0] o_rkey, o_rorder, h_rkey, h_rorder, cmp_key;
  logic            key_eq, o_hit, o_end, h_hit, h_end;
  logic [OAW-1:0]  oidx_next;
  logic [HAW-1:0]  hslot_next, head_next;

  assign o_rkey   = o_rdata[ENTRY_W-1 -: ID_W];
  assign o_rorder = o_rdata[ID_W-1:0];
  assign h_rkey   = h_rdata[ENTRY_W-1 -: ID_W];
  assign h_rorder = h_rdata[ID_W-1:0];

  assign busy      = (state != S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    oidx_next  = (oidx == O_LAST) ? '0 : oidx + 1'b1;
    hslot_next = (hslot == H_LAST) ? '0 : hslot + 1'b1;
    head_next  = (hist_head == H_LAST) ? '0 : hist_head + 1'b1;

    // the one comparator, shared by both scans
    cmp_key = (state == S_HSCAN) ? h_rkey : o_rkey;
    key_eq  = (cmp_key == key);

    o_hit = (state == S_OSCAN) && ochk && open_valid[ochk_idx] && key_eq;
    o_end = (state == S_OSCAN) && ochk && (o_hit || ochk_idx == O_LAST);
    h_hit = (state == S_HSCAN) && hchk && key_eq;
    h_end = (state == S_HSCAN) && hchk && (h_hit || hchk_last);

    o_we    = o_end && !o_hit && (act == ACT_ADD) && free_fnd;
    o_waddr = free_idx;
    o_wdata = {key, ord};
    o_raddr = oidx;

    // hslot ends the scan on the push slot; with an empty history it is the head
    h_we    = (o_end && o_hit && (act == ACT_CLOSE) && (hist_count == '0)) ||
              (h_end && !h_hit && (act == ACT_CLOSE));
    h_waddr = hslot;
    h_wdata = {key, (state == S_OSCAN) ? o_rorder : hit_order};
    h_raddr = hslot;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      open_valid <= '0;
      hist_head  <= '0;
      hist_count <= '0;
      ochk       <= 1'b0;
      hchk       <= 1'b0;
      free_fnd   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            act      <= req.action;
            key      <= req.client_id;
            ord      <= req.order_id;
            oidx     <= '0;
            ochk     <= 1'b0;
            free_fnd <= 1'b0;
            hslot    <= hist_head;
            hn       <= '0;
            hchk     <= 1'b0;
            res      <= '0;
            if (req.action == ACT_ADD || req.action == ACT_CLOSE ||
                req.action == ACT_LOOKUP) begin
              state <= S_OSCAN;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_OSCAN: begin
          oidx     <= oidx_next;
          ochk     <= !o_end;
          ochk_idx <= oidx;
          if (!free_fnd && !open_valid[oidx]) begin
            free_fnd <= 1'b1;
            free_idx <= oidx;
          end
          if (o_end) begin
            case (act)
              ACT_ADD: begin
                state <= S_DONE;
                if (o_hit) begin
                  res.status <= ST_DUPLICATE;
                end else if (free_fnd) begin
                  res.status           <= ST_OK;
                  open_valid[free_idx] <= 1'b1;
                end else begin
                  res.status <= ST_FULL;
                end
              end
              ACT_CLOSE: begin
                if (!o_hit) begin
                  state      <= S_DONE;
                  res.status <= ST_NOT_FOUND;
                end else begin
                  open_valid[ochk_idx] <= 1'b0;
                  hit_order            <= o_rorder;
                  res.status           <= ST_OK;
                  if (hist_count == '0) begin
                    state      <= S_DONE;
                    hist_count <= hist_count + 1'b1;
                  end else begin
                    state <= S_HSCAN;
                  end
                end
              end
              ACT_LOOKUP: begin
                if (o_hit) begin
                  state           <= S_DONE;
                  res.found_order <= o_rorder;
                  res.status      <= ST_OK;
                end else if (hist_count == '0) begin
                  state      <= S_DONE;
                  res.status <= ST_NOT_FOUND;
                end else begin
                  state <= S_HSCAN;
                end
              end
              default: begin
                state <= S_DONE;
                res   <= '0;
              end
            endcase
          end
        end
        S_HSCAN: begin
          if (hn < hist_count) begin
            hslot     <= hslot_next;
            hn        <= hn + 1'b1;
            hchk_last <= (CW'(hn + 1'b1) == hist_count);
          end
          hchk <= (hn < hist_count) && !h_end;
          if (h_end) begin
            state <= S_DONE;
            if (act == ACT_LOOKUP) begin
              if (h_hit) begin
                res.found_order  <= h_rorder;
                res.from_history <= 1'b1;
                res.status       <= ST_OK;
              end else begin
                res.status <= ST_NOT_FOUND;
              end
            end else begin
              res.status <= ST_OK;
              if (!h_hit) begin
                if (hist_count != H_FULL) begin
                  hist_count <= hist_count + 1'b1;
                end else begin
                  hist_head <= head_next;
                end
              end
            end
          end
        end
        S_DONE: begin
          if (res_take) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_hist_bound: assert property (@(posedge clk) disable iff (rst)
    hist_count <= H_FULL)
    else $error("history count above depth");

  a_add_free: assert property (@(posedge clk) disable iff (rst)
    o_we |-> !open_valid[o_waddr])
    else $error("add overwrites a live open entry");

  a_push_grow: assert property (@(posedge clk) disable iff (rst)
    h_we && (hist_count != H_FULL) |=> hist_count == CW'($past(hist_count) + 1'b1))
    else $error("history push did not grow the count");

  a_push_wrap: assert property (@(posedge clk) disable iff (rst)
    h_we && (hist_count == H_FULL) |=> hist_head != $past(hist_head) || HISTORY_DEPTH == 1)
    else $error("full history push did not advance the head");

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE) && !res_take |=> (state == S_DONE) && $stable(res))
    else $error("pending result changed");

endmodule
